### rtl/wbgs_pkg.sv
// shared types and constants of the weighbridge barrier gate sequencer
package wbgs_pkg;

    // close sequencer phases, as reported in close_phase
    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_PREPARE = 2'd1,
        PH_WAIT    = 2'd2,
        PH_PROTECT = 2'd3
    } phase_t;

    // configuration register indexes
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 32;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_EMPTY_WEIGHT_LIMIT = 3'd0,
        CFG_RISE_LIMIT         = 3'd1,
        CFG_CONFIRM_TICKS      = 3'd2,
        CFG_DISTURB_TICKS      = 3'd3,
        CFG_PROTECT_TICKS      = 3'd4,
        CFG_PULSE_TICKS        = 3'd5
    } cfg_index_t;

    // fixed register widths
    localparam int RISE_LIMIT_BITS = 23;
    localparam int SHORT_COUNT_BITS = 8;
    localparam int LIMIT_TICK_BITS = 16;

    // register reset values
    localparam int EMPTY_WEIGHT_LIMIT_RESET = 350;
    localparam logic [RISE_LIMIT_BITS-1:0]  RISE_LIMIT_RESET    = 23'd500;
    localparam logic [SHORT_COUNT_BITS-1:0] CONFIRM_TICKS_RESET = 8'd3;
    localparam logic [SHORT_COUNT_BITS-1:0] DISTURB_TICKS_RESET = 8'd4;
    localparam logic [LIMIT_TICK_BITS-1:0]  PROTECT_TICKS_RESET = 16'd300;
    localparam logic [LIMIT_TICK_BITS-1:0]  PULSE_TICKS_RESET   = 16'd100;

endpackage

### rtl/wbgs_if.sv
// channel interfaces: tick items, result items and configuration writes
interface wbgs_tick_if #(
    parameter int WEIGHT_BITS = 24
);
    logic                          valid;
    logic                          ready;
    logic signed [WEIGHT_BITS-1:0] weight;
    logic                          grating_blocked;
    logic                          coil_occupied;
    logic                          open_request;

    modport source (
        output valid, weight, grating_blocked, coil_occupied, open_request,
        input  ready
    );
    modport sink (
        input  valid, weight, grating_blocked, coil_occupied, open_request,
        output ready
    );
endinterface

interface wbgs_result_if
    import wbgs_pkg::*;
;
    logic   valid;
    logic   ready;
    logic   open_relay_on;
    logic   close_relay_on;
    logic   gate_closed;
    phase_t close_phase;

    modport source (
        output valid, open_relay_on, close_relay_on, gate_closed, close_phase,
        input  ready
    );
    modport sink (
        input  valid, open_relay_on, close_relay_on, gate_closed, close_phase,
        output ready
    );
endinterface

interface wbgs_cfg_if
    import wbgs_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic [CFG_INDEX_BITS-1:0] index;
    logic [CFG_DATA_BITS-1:0]  data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

### rtl/wbgs_core.sv
// configuration registers, sequencer state and the per-tick next-state logic
module wbgs_core
    import wbgs_pkg::*;
#(
    parameter int WEIGHT_BITS     = 24,
    parameter int TICK_COUNT_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          advance,
    input  logic                          cfg_write,
    input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [CFG_DATA_BITS-1:0]      cfg_data,
    input  logic signed [WEIGHT_BITS-1:0] weight,
    input  logic                          grating_blocked,
    input  logic                          coil_occupied,
    input  logic                          open_request,
    output logic                          open_relay_on,
    output logic                          close_relay_on,
    output logic                          gate_closed,
    output phase_t                        close_phase
);

    // compare widths: tick counters against 16-bit limits, weight rise
    localparam int CMP_BITS  = (TICK_COUNT_BITS > LIMIT_TICK_BITS) ?
                               TICK_COUNT_BITS : LIMIT_TICK_BITS;
    localparam int DIFF_BITS = ((WEIGHT_BITS > RISE_LIMIT_BITS) ?
                                WEIGHT_BITS : RISE_LIMIT_BITS) + 2;

    // configuration registers
    logic signed [WEIGHT_BITS-1:0]  empty_weight_limit_reg;
    logic [RISE_LIMIT_BITS-1:0]     rise_limit_reg;
    logic [SHORT_COUNT_BITS-1:0]    confirm_ticks_reg;
    logic [SHORT_COUNT_BITS-1:0]    disturb_ticks_reg;
    logic [LIMIT_TICK_BITS-1:0]     protect_ticks_reg;
    logic [LIMIT_TICK_BITS-1:0]     pulse_ticks_reg;

    // sequencer state
    phase_t                         phase_reg, phase_next;
    logic [SHORT_COUNT_BITS-1:0]    confirm_count_reg, confirm_count_next;
    logic [SHORT_COUNT_BITS-1:0]    disturb_count_reg, disturb_count_next;
    logic signed [WEIGHT_BITS-1:0]  reference_weight_reg, reference_weight_next;
    logic [TICK_COUNT_BITS-1:0]     protect_count_reg, protect_count_next;
    logic                           pulse_active_reg, pulse_active_next;
    logic [TICK_COUNT_BITS-1:0]     pulse_count_reg, pulse_count_next;
    logic                           closed_flag_reg, closed_flag_next;
    logic                           relay_open_reg, relay_open_next;
    logic                           relay_close_reg, relay_close_next;

    // per-tick helpers
    logic                           both_active;
    logic [SHORT_COUNT_BITS-1:0]    confirm_inc;
    logic                           confirm_done;
    logic [SHORT_COUNT_BITS-1:0]    disturb_inc;
    logic [TICK_COUNT_BITS-1:0]     protect_inc;
    logic signed [DIFF_BITS-1:0]    weight_rise;
    logic signed [DIFF_BITS-1:0]    rise_limit_ext;
    logic                           cmd_issue;
    logic                           cmd_close;
    logic [TICK_COUNT_BITS-1:0]     pulse_inc;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            empty_weight_limit_reg <= WEIGHT_BITS'(EMPTY_WEIGHT_LIMIT_RESET);
            rise_limit_reg         <= RISE_LIMIT_RESET;
            confirm_ticks_reg      <= CONFIRM_TICKS_RESET;
            disturb_ticks_reg      <= DISTURB_TICKS_RESET;
            protect_ticks_reg      <= PROTECT_TICKS_RESET;
            pulse_ticks_reg        <= PULSE_TICKS_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_EMPTY_WEIGHT_LIMIT: empty_weight_limit_reg <= cfg_data[WEIGHT_BITS-1:0];
                CFG_RISE_LIMIT:         rise_limit_reg <= cfg_data[RISE_LIMIT_BITS-1:0];
                CFG_CONFIRM_TICKS:      confirm_ticks_reg <= cfg_data[SHORT_COUNT_BITS-1:0];
                CFG_DISTURB_TICKS:      disturb_ticks_reg <= cfg_data[SHORT_COUNT_BITS-1:0];
                CFG_PROTECT_TICKS:      protect_ticks_reg <= cfg_data[LIMIT_TICK_BITS-1:0];
                CFG_PULSE_TICKS:        pulse_ticks_reg <= cfg_data[LIMIT_TICK_BITS-1:0];
                default:                ;
            endcase
        end
    end

    // shared increments and compares
    assign both_active    = grating_blocked && coil_occupied;
    assign confirm_inc    = confirm_count_reg + 8'd1;
    assign confirm_done   = (confirm_inc >= confirm_ticks_reg);
    assign disturb_inc    = disturb_count_reg + 8'd1;
    assign protect_inc    = protect_count_reg + TICK_COUNT_BITS'(1);
    assign weight_rise    = DIFF_BITS'(weight) - DIFF_BITS'(reference_weight_reg);
    assign rise_limit_ext = $signed(DIFF_BITS'(rise_limit_reg));

    // next state for one tick
    always_comb
    begin
        phase_next            = phase_reg;
        confirm_count_next    = confirm_count_reg;
        disturb_count_next    = disturb_count_reg;
        reference_weight_next = reference_weight_reg;
        protect_count_next    = protect_count_reg;
        cmd_issue             = 1'b0;
        cmd_close             = 1'b0;

        // empty scale opens a closed gate
        if ((weight < empty_weight_limit_reg) && closed_flag_reg)
        begin
            cmd_issue = 1'b1;
            cmd_close = 1'b0;
        end

        if (open_request)
        begin
            cmd_issue = 1'b1;
            cmd_close = 1'b0;
        end
        else
        begin
            case (phase_reg)
                PH_IDLE:
                begin
                    if (both_active)
                    begin
                        confirm_count_next = confirm_inc;
                        if (confirm_done)
                        begin
                            confirm_count_next    = '0;
                            reference_weight_next = weight;
                            phase_next            = PH_PREPARE;
                        end
                    end
                end
                PH_PREPARE:
                begin
                    if (!grating_blocked && !coil_occupied)
                    begin
                        confirm_count_next = '0;
                        phase_next         = PH_WAIT;
                    end
                end
                PH_WAIT:
                begin
                    if (both_active)
                    begin
                        disturb_count_next = '0;
                        confirm_count_next = confirm_inc;
                        if (confirm_done)
                        begin
                            confirm_count_next    = '0;
                            reference_weight_next = weight;
                            phase_next            = PH_PREPARE;
                        end
                    end
                    else if (weight_rise > rise_limit_ext)
                    begin
                        disturb_count_next = '0;
                        protect_count_next = '0;
                        cmd_issue          = 1'b1;
                        cmd_close          = 1'b1;
                        phase_next         = PH_PROTECT;
                    end
                    else
                    begin
                        disturb_count_next = disturb_inc;
                        if (disturb_inc >= disturb_ticks_reg)
                        begin
                            disturb_count_next = '0;
                            phase_next         = PH_IDLE;
                        end
                    end
                end
                PH_PROTECT:
                begin
                    protect_count_next = protect_inc;
                    if (CMP_BITS'(protect_inc) >= CMP_BITS'(protect_ticks_reg))
                    begin
                        protect_count_next = '0;
                        phase_next         = PH_IDLE;
                    end
                    // grating trips again: reopen
                    if (grating_blocked)
                    begin
                        cmd_issue  = 1'b1;
                        cmd_close  = 1'b0;
                        phase_next = PH_IDLE;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end

        // command drives one relay and restarts the pulse timer
        closed_flag_next  = cmd_issue ? cmd_close : closed_flag_reg;
        relay_open_next   = cmd_issue ? !cmd_close : relay_open_reg;
        relay_close_next  = cmd_issue ? cmd_close : relay_close_reg;
        pulse_active_next = cmd_issue || pulse_active_reg;
        pulse_inc         = (cmd_issue ? '0 : pulse_count_reg) + TICK_COUNT_BITS'(1);
        pulse_count_next  = cmd_issue ? '0 : pulse_count_reg;

        // pulse timer advances, releasing both relays at the end
        if (pulse_active_next)
        begin
            pulse_count_next = pulse_inc;
            if (CMP_BITS'(pulse_inc) >= CMP_BITS'(pulse_ticks_reg))
            begin
                pulse_count_next  = '0;
                pulse_active_next = 1'b0;
                relay_open_next   = 1'b0;
                relay_close_next  = 1'b0;
            end
        end
    end

    // result fields reflect the state after the tick
    always_comb
    begin
        open_relay_on  = relay_open_next;
        close_relay_on = relay_close_next;
        gate_closed    = closed_flag_next;
        close_phase    = phase_next;
    end

    // state commits when the tick moves to the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg            <= PH_IDLE;
            confirm_count_reg    <= '0;
            disturb_count_reg    <= '0;
            reference_weight_reg <= '0;
            protect_count_reg    <= '0;
            pulse_active_reg     <= 1'b0;
            pulse_count_reg      <= '0;
            closed_flag_reg      <= 1'b0;
            relay_open_reg       <= 1'b0;
            relay_close_reg      <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg            <= phase_next;
            confirm_count_reg    <= confirm_count_next;
            disturb_count_reg    <= disturb_count_next;
            reference_weight_reg <= reference_weight_next;
            protect_count_reg    <= protect_count_next;
            pulse_active_reg     <= pulse_active_next;
            pulse_count_reg      <= pulse_count_next;
            closed_flag_reg      <= closed_flag_next;
            relay_open_reg       <= relay_open_next;
            relay_close_reg      <= relay_close_next;
        end
    end

endmodule

### rtl/weighbridge_barrier_gate_sequencer.sv
// weighbridge barrier gate sequencer top level: input register, core, result register
//
//  channel  | direction | carries
//  ---------+-----------+------------------------------------------------------
//  tick     | in        | weight, grating_blocked, coil_occupied, open_request
//  result   | out       | open_relay_on, close_relay_on, gate_closed, close_phase
//  cfg      | in        | index, data (register write, always ready)
//
//  one item per cycle sustained while results are taken; a tick is captured in the
//  input register and its result in the result register when the tick advances
//  the rate is set by the combinational next-state logic between the two registers
//  reset clears the sequencer state and both valid flags and loads register defaults
//  a stalled result holds the result register and then the input register, and
//  tick ready drops only when both are full and the result is not taken
module weighbridge_barrier_gate_sequencer
    import wbgs_pkg::*;
#(
    parameter int WEIGHT_BITS     = 24,
    parameter int TICK_COUNT_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    wbgs_tick_if.sink            tick,
    wbgs_result_if.source        result,
    wbgs_cfg_if.sink             cfg
);

    // input register
    logic                          in_valid_reg;
    logic signed [WEIGHT_BITS-1:0] weight_reg;
    logic                          grating_reg;
    logic                          coil_reg;
    logic                          request_reg;

    // result register
    logic                          out_valid_reg;
    logic                          open_relay_reg;
    logic                          close_relay_reg;
    logic                          gate_closed_reg;
    phase_t                        close_phase_reg;

    // core outputs
    logic                          open_relay_next;
    logic                          close_relay_next;
    logic                          gate_closed_next;
    phase_t                        close_phase_next;

    logic                          advance;
    logic                          tick_take;

    // handshakes
    assign advance    = in_valid_reg && (!out_valid_reg || result.ready);
    assign tick.ready = !in_valid_reg || advance;
    assign tick_take  = tick.valid && tick.ready;
    assign cfg.ready  = 1'b1;

    wbgs_core #(
        .WEIGHT_BITS     (WEIGHT_BITS),
        .TICK_COUNT_BITS (TICK_COUNT_BITS)
    ) u_core (
        .clk             (clk),
        .rst_n           (rst_n),
        .advance         (advance),
        .cfg_write       (cfg.valid),
        .cfg_index       (cfg.index),
        .cfg_data        (cfg.data),
        .weight          (weight_reg),
        .grating_blocked (grating_reg),
        .coil_occupied   (coil_reg),
        .open_request    (request_reg),
        .open_relay_on   (open_relay_next),
        .close_relay_on  (close_relay_next),
        .gate_closed     (gate_closed_next),
        .close_phase     (close_phase_next)
    );

    // input register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (tick.ready)
        begin
            in_valid_reg <= tick.valid;
        end
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (tick_take)
        begin
            weight_reg  <= tick.weight;
            grating_reg <= tick.grating_blocked;
            coil_reg    <= tick.coil_occupied;
            request_reg <= tick.open_request;
        end
    end

    // result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            open_relay_reg  <= open_relay_next;
            close_relay_reg <= close_relay_next;
            gate_closed_reg <= gate_closed_next;
            close_phase_reg <= close_phase_next;
        end
    end

    // result channel
    assign result.valid          = out_valid_reg;
    assign result.open_relay_on  = open_relay_reg;
    assign result.close_relay_on = close_relay_reg;
    assign result.gate_closed    = gate_closed_reg;
    assign result.close_phase    = close_phase_reg;

endmodule

### dv/weighbridge_barrier_gate_sequencer_tb.sv
// testbench for the weighbridge barrier gate sequencer: directed and steered random ticks
`timescale 1ns / 1ps

module weighbridge_barrier_gate_sequencer_tb;
    import wbgs_pkg::*;

    localparam int     WB          = 24;
    localparam longint W_MAX       = 8388607;
    localparam longint W_MIN       = -8388608;
    localparam int     HOLD_CYCLES = 120;

    // one result item as the block reports it
    typedef struct packed {
        logic   open_on;
        logic   close_on;
        logic   closed;
        phase_t phase;
    } gate_status_t;

    logic clk = 1'b0;
    logic rst_n;

    wbgs_tick_if #(.WEIGHT_BITS(WB)) tick_ch ();
    wbgs_result_if                   result_ch ();
    wbgs_cfg_if                      cfg_ch ();

    weighbridge_barrier_gate_sequencer #(
        .WEIGHT_BITS     (WB),
        .TICK_COUNT_BITS (16)
    ) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .tick   (tick_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    // gate model limits
    logic signed [WB-1:0]              lim_empty;
    logic [RISE_LIMIT_BITS-1:0]        lim_rise;
    logic [SHORT_COUNT_BITS-1:0]       lim_confirm;
    logic [SHORT_COUNT_BITS-1:0]       lim_disturb;
    logic [LIMIT_TICK_BITS-1:0]        lim_protect;
    logic [LIMIT_TICK_BITS-1:0]        lim_pulse;

    // gate model state
    phase_t                            gs_phase;
    logic [SHORT_COUNT_BITS-1:0]       gs_confirm_cnt;
    logic [SHORT_COUNT_BITS-1:0]       gs_disturb_cnt;
    logic signed [WB-1:0]              gs_ref_weight;
    logic [15:0]                       gs_protect_cnt;
    logic                              gs_pulse_active;
    logic [15:0]                       gs_pulse_cnt;
    logic                              gs_closed;
    logic                              gs_open_relay;
    logic                              gs_close_relay;

    gate_status_t status_q[$];
    int           mismatch_count = 0;
    bit           idle_on        = 1'b1;
    bit           hold_request   = 1'b0;

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(4, 24);
    endfunction

    function automatic void reset_gate_model();
        lim_empty       = WB'(EMPTY_WEIGHT_LIMIT_RESET);
        lim_rise        = RISE_LIMIT_RESET;
        lim_confirm     = CONFIRM_TICKS_RESET;
        lim_disturb     = DISTURB_TICKS_RESET;
        lim_protect     = PROTECT_TICKS_RESET;
        lim_pulse       = PULSE_TICKS_RESET;
        gs_phase        = PH_IDLE;
        gs_confirm_cnt  = '0;
        gs_disturb_cnt  = '0;
        gs_ref_weight   = '0;
        gs_protect_cnt  = '0;
        gs_pulse_active = 1'b0;
        gs_pulse_cnt    = '0;
        gs_closed       = 1'b0;
        gs_open_relay   = 1'b0;
        gs_close_relay  = 1'b0;
    endfunction

    // open or close command: one relay on, pulse timer restarted
    function automatic void drive_gate(input logic close_it);
        gs_pulse_active = 1'b1;
        gs_pulse_cnt    = '0;
        gs_closed       = close_it;
        gs_open_relay   = !close_it;
        gs_close_relay  = close_it;
    endfunction

    // both sensors active: count toward prepare and latch the weight
    function automatic void advance_confirm(input logic signed [WB-1:0] w);
        gs_confirm_cnt = gs_confirm_cnt + 1'b1;
        if (gs_confirm_cnt >= lim_confirm)
        begin
            gs_confirm_cnt = '0;
            gs_ref_weight  = w;
            gs_phase       = PH_PREPARE;
        end
    endfunction

    // one tick through the gate model, expected status queued
    function automatic void step_gate_model(input logic signed [WB-1:0] w,
                                            input logic g, input logic c, input logic r);
        logic         both;
        gate_status_t st;
        both = g && c;

        if (w < lim_empty && gs_closed)
            drive_gate(1'b0);

        if (r)
            drive_gate(1'b0);
        else
        begin
            case (gs_phase)
                PH_IDLE:
                begin
                    if (both)
                        advance_confirm(w);
                end
                PH_PREPARE:
                begin
                    if (!g && !c)
                    begin
                        gs_confirm_cnt = '0;
                        gs_phase       = PH_WAIT;
                    end
                end
                PH_WAIT:
                begin
                    if (both)
                    begin
                        gs_disturb_cnt = '0;
                        advance_confirm(w);
                    end
                    else if (longint'(w) - longint'(gs_ref_weight) > longint'(lim_rise))
                    begin
                        gs_disturb_cnt = '0;
                        gs_protect_cnt = '0;
                        drive_gate(1'b1);
                        gs_phase = PH_PROTECT;
                    end
                    else
                    begin
                        gs_disturb_cnt = gs_disturb_cnt + 1'b1;
                        if (gs_disturb_cnt >= lim_disturb)
                        begin
                            gs_disturb_cnt = '0;
                            gs_phase       = PH_IDLE;
                        end
                    end
                end
                default:
                begin
                    gs_protect_cnt = gs_protect_cnt + 1'b1;
                    if (gs_protect_cnt >= lim_protect)
                    begin
                        gs_protect_cnt = '0;
                        gs_phase       = PH_IDLE;
                    end
                    if (g)
                    begin
                        drive_gate(1'b0);
                        gs_phase = PH_IDLE;
                    end
                end
            endcase
        end

        // relay pulse timer
        if (gs_pulse_active)
        begin
            gs_pulse_cnt = gs_pulse_cnt + 1'b1;
            if (gs_pulse_cnt >= lim_pulse)
            begin
                gs_pulse_cnt    = '0;
                gs_pulse_active = 1'b0;
                gs_open_relay   = 1'b0;
                gs_close_relay  = 1'b0;
            end
        end

        st.open_on  = gs_open_relay;
        st.close_on = gs_close_relay;
        st.closed   = gs_closed;
        st.phase    = gs_phase;
        status_q.push_back(st);
    endfunction

    // offer one tick item, predict once it is taken
    task automatic send_tick(input logic signed [WB-1:0] w,
                             input logic g, input logic c, input logic r);
        int gap;
        gap = idle_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            tick_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        tick_ch.valid           <= 1'b1;
        tick_ch.weight          <= w;
        tick_ch.grating_blocked <= g;
        tick_ch.coil_occupied   <= c;
        tick_ch.open_request    <= r;
        do
            @(posedge clk);
        while (!tick_ch.ready);
        step_gate_model(w, g, c, r);
    endtask

    // stop offering ticks and wait until every status item is back
    task automatic settle();
        tick_ch.valid <= 1'b0;
        while (status_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_BITS-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        case (idx)
            CFG_EMPTY_WEIGHT_LIMIT: lim_empty   = val[WB-1:0];
            CFG_RISE_LIMIT:         lim_rise    = val[RISE_LIMIT_BITS-1:0];
            CFG_CONFIRM_TICKS:      lim_confirm = val[SHORT_COUNT_BITS-1:0];
            CFG_DISTURB_TICKS:      lim_disturb = val[SHORT_COUNT_BITS-1:0];
            CFG_PROTECT_TICKS:      lim_protect = val[LIMIT_TICK_BITS-1:0];
            CFG_PULSE_TICKS:        lim_pulse   = val[LIMIT_TICK_BITS-1:0];
            default: ;
        endcase
    endtask

    // rewrite all limits while the block is idle
    task automatic set_limits(input longint empty_lim, input longint rise_lim,
                              input int confirm, input int disturb,
                              input int protect, input int pulse);
        settle();
        write_reg(CFG_EMPTY_WEIGHT_LIMIT, 32'(empty_lim));
        write_reg(CFG_RISE_LIMIT,         32'(rise_lim));
        write_reg(CFG_CONFIRM_TICKS,      32'(confirm));
        write_reg(CFG_DISTURB_TICKS,      32'(disturb));
        write_reg(CFG_PROTECT_TICKS,      32'(protect));
        write_reg(CFG_PULSE_TICKS,        32'(pulse));
        cfg_ch.valid <= 1'b0;
    endtask

    // traffic tick steered by the modeled phase, with some noise
    task automatic send_traffic_tick();
        longint lw;
        logic   g;
        logic   c;
        logic   r;
        int     sel;
        longint quiet_span;
        g   = 1'b0;
        c   = 1'b0;
        r   = ($urandom_range(0, 39) == 0);
        sel = $urandom_range(0, 99);
        lw  = longint'($urandom_range(0, 40000));
        quiet_span = (lim_rise > 1000) ? 1000 : longint'(lim_rise);

        if ($urandom_range(0, 9) == 0)
        begin
            // fully random item
            lw = longint'($signed(WB'($urandom)));
            g  = 1'($urandom_range(0, 1));
            c  = 1'($urandom_range(0, 1));
            r  = 1'($urandom_range(0, 1));
        end
        else
        begin
            case (gs_phase)
                PH_IDLE:
                begin
                    if (sel < 85)
                    begin
                        g = 1'b1;
                        c = 1'b1;
                    end
                    else
                    begin
                        g = 1'($urandom_range(0, 1));
                        c = 1'($urandom_range(0, 1));
                    end
                end
                PH_PREPARE:
                begin
                    lw = longint'(gs_ref_weight) + longint'($urandom_range(0, 400)) - 200;
                    if (sel >= 60 && sel < 85)
                    begin
                        g = 1'($urandom_range(0, 1));
                        c = !g;
                    end
                    else if (sel >= 85)
                    begin
                        g = 1'b1;
                        c = 1'b1;
                    end
                end
                PH_WAIT:
                begin
                    if (sel < 50)
                        lw = longint'(gs_ref_weight) + longint'(lim_rise) + 1
                             + longint'($urandom_range(0, 255));
                    else if (sel < 85)
                        lw = longint'(gs_ref_weight) - longint'($urandom_range(0, 1000))
                             + longint'($urandom_range(0, quiet_span));
                    else
                    begin
                        g = 1'b1;
                        c = 1'b1;
                    end
                end
                default:
                begin
                    g  = ($urandom_range(0, 9) == 0);
                    c  = 1'($urandom_range(0, 1));
                    lw = longint'(gs_ref_weight) + longint'(lim_rise)
                         + longint'($urandom_range(0, 2000));
                end
            endcase
            // now and then the scale reads empty
            if ($urandom_range(0, 19) == 0)
                lw = longint'(lim_empty) - 1 - longint'($urandom_range(0, 100));
        end

        if (lw > W_MAX)
            lw = W_MAX;
        if (lw < W_MIN)
            lw = W_MIN;
        send_tick(WB'(lw), g, c, r);
    endtask

    // reset limits: three ticks of both sensors reach prepare
    task automatic test_reset_values();
        repeat (3) send_tick(24'sd100, 1'b1, 1'b1, 1'b0);
    endtask

    // open request, prepare, wait with disturbances, close, lowered protect limit
    task automatic test_close_sequence();
        set_limits(W_MIN, 0, 1, 2, 65535, 0);
        send_tick(24'sd0, 1'b1, 1'b0, 1'b0);
        send_tick(24'sd0, 1'b0, 1'b0, 1'b1);
        send_tick(24'sd0, 1'b0, 1'b0, 1'b0);
        send_tick(24'sd0, 1'b0, 1'b0, 1'b0);
        send_tick(24'sd0, 1'b1, 1'b1, 1'b0);
        send_tick(24'sd0, 1'b0, 1'b0, 1'b0);
        send_tick(24'sd0, 1'b0, 1'b0, 1'b0);
        send_tick(24'sd0, 1'b0, 1'b0, 1'b0);
        send_tick(WB'(W_MIN), 1'b1, 1'b1, 1'b0);
        send_tick(24'sd0, 1'b0, 1'b0, 1'b0);
        send_tick(WB'(W_MAX), 1'b0, 1'b1, 1'b0);
        send_tick(24'sd0, 1'b0, 1'b1, 1'b0);
        // protect limit drops below the running count
        set_limits(W_MIN, 0, 1, 2, 1, 0);
        send_tick(24'sd0, 1'b0, 1'b0, 1'b0);
    endtask

    // empty scale opens a closed gate; a request restarts the long pulse
    task automatic test_empty_open();
        set_limits(W_MAX, 0, 1, 2, 1, 65535);
        send_tick(24'sd0, 1'b0, 1'b0, 1'b0);
        send_tick(24'sd0, 1'b0, 1'b0, 1'b1);
    endtask

    // rise from the lowest reference to the highest weight against the top rise limit
    task automatic test_full_range_rise();
        set_limits(W_MIN, W_MAX, 1, 2, 1, 2);
        send_tick(WB'(W_MIN), 1'b1, 1'b1, 1'b0);
        send_tick(24'sd0, 1'b0, 1'b0, 1'b0);
        send_tick(WB'(W_MAX), 1'b0, 1'b0, 1'b0);
        send_tick(24'sd0, 1'b1, 1'b0, 1'b0);
    endtask

    // empty open and rise close in one tick, rise exactly at the limit first
    task automatic test_double_command();
        set_limits(-1000, 0, 1, 2, 1, 2);
        send_tick(-24'sd100, 1'b1, 1'b1, 1'b0);
        send_tick(24'sd0, 1'b0, 1'b0, 1'b0);
        send_tick(-24'sd100, 1'b0, 1'b0, 1'b0);
        send_tick(24'sd0, 1'b0, 1'b0, 1'b0);
        send_tick(24'sd0, 1'b0, 1'b0, 1'b0);
        send_tick(-24'sd100, 1'b1, 1'b1, 1'b0);
        send_tick(24'sd0, 1'b0, 1'b0, 1'b0);
        set_limits(0, 0, 1, 2, 1, 2);
        send_tick(-24'sd50, 1'b0, 1'b0, 1'b0);
    endtask

    // phases of steered traffic: top limits, bottom limits, then random small ones
    task automatic test_random_traffic();
        for (int ph = 0; ph < 9; ph++)
        begin
            if (ph == 0)
                set_limits(W_MAX, W_MAX, 255, 255, 65535, 65535);
            else if (ph == 1)
                set_limits(W_MIN, 0, 1, 1, 1, 1);
            else
                set_limits(longint'($urandom_range(0, 4000)) - 1000,
                           longint'($urandom_range(0, 2000)),
                           $urandom_range(1, 6), $urandom_range(1, 8),
                           $urandom_range(1, 25), $urandom_range(1, 40));
            // one phase runs without any idling
            idle_on = (ph != 4);
            repeat (100) send_traffic_tick();
        end
        idle_on = 1'b1;
    endtask

    // result side holds off while ticks keep coming back to back
    task automatic test_output_stall();
        settle();
        idle_on      = 1'b0;
        hold_request = 1'b1;
        repeat (40) send_traffic_tick();
        idle_on = 1'b1;
    endtask

    // result ready: random stalls plus the long hold-off on request
    initial
    begin
        int hold_left;
        int stall_left;
        hold_left  = 0;
        stall_left = 0;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                result_ch.ready <= 1'b0;
                hold_left--;
            end
            else if (stall_left > 0)
            begin
                result_ch.ready <= 1'b0;
                stall_left--;
            end
            else if (idle_on && $urandom_range(0, 3) == 0)
            begin
                result_ch.ready <= 1'b0;
                stall_left = pick_gap();
            end
            else
                result_ch.ready <= 1'b1;
        end
    end

    // compare each taken result item with the oldest expected status
    always @(posedge clk)
    begin
        gate_status_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (status_q.size() == 0)
            begin
                $error("result item with no expected status");
                mismatch_count++;
            end
            else
            begin
                want = status_q.pop_front();
                if (result_ch.open_relay_on !== want.open_on)
                begin
                    $error("open_relay_on: expected %0b, actual %0b",
                           want.open_on, result_ch.open_relay_on);
                    mismatch_count++;
                end
                if (result_ch.close_relay_on !== want.close_on)
                begin
                    $error("close_relay_on: expected %0b, actual %0b",
                           want.close_on, result_ch.close_relay_on);
                    mismatch_count++;
                end
                if (result_ch.gate_closed !== want.closed)
                begin
                    $error("gate_closed: expected %0b, actual %0b",
                           want.closed, result_ch.gate_closed);
                    mismatch_count++;
                end
                if (result_ch.close_phase !== want.phase)
                begin
                    $error("close_phase: expected %0d, actual %0d",
                           want.phase, result_ch.close_phase);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog
    initial
    begin
        #2000000;
        $display("weighbridge_barrier_gate_sequencer regression: fail");
        $finish;
    end

    // test sequence
    initial
    begin
        rst_n                   <= 1'b0;
        tick_ch.valid           <= 1'b0;
        tick_ch.weight          <= '0;
        tick_ch.grating_blocked <= 1'b0;
        tick_ch.coil_occupied   <= 1'b0;
        tick_ch.open_request    <= 1'b0;
        cfg_ch.valid            <= 1'b0;
        cfg_ch.index            <= CFG_EMPTY_WEIGHT_LIMIT;
        cfg_ch.data             <= '0;
        reset_gate_model();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_values();
        test_close_sequence();
        test_empty_open();
        test_full_range_rise();
        test_double_command();
        test_random_traffic();
        test_output_stall();

        settle();
        repeat (8) @(posedge clk);
        if (status_q.size() != 0)
        begin
            $error("%0d expected status items never arrived", status_q.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("weighbridge_barrier_gate_sequencer regression: pass");
        else
            $display("weighbridge_barrier_gate_sequencer regression: fail");
        $finish;
    end

endmodule
